// ===== sv/range_affine_update_point_query_macros.svh =====
// Assertion macros for the checker of the range affine update block.
// Depends on nothing; include by bare file name.
`ifndef RANGE_AFFINE_UPDATE_POINT_QUERY_MACROS_SVH
`define RANGE_AFFINE_UPDATE_POINT_QUERY_MACROS_SVH

// Same-cycle implication, reset term given by the caller.
`define RAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset term given by the caller.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rau_pkg.sv =====
// Shared types and constants of the range affine update block.
// Depends on nothing; used by the datapath, the top level and the checker.
package rau_pkg;

  localparam int IDX_W  = 11;
  localparam int VAL_W  = 30;
  localparam int KIND_W = 2;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_QUERY = 2'd1;
  localparam kind_t KIND_ADD   = 2'd2;
  localparam kind_t KIND_MUL   = 2'd3;

  localparam val_t PRIME   = 30'd1000000007;
  localparam val_t VAL_ONE = 30'd1;

  // floor(2^60 / PRIME) for Barrett reduction of a 60-bit product
  localparam logic [30:0] BARRETT_M = 31'(64'h1000000000000000 / 64'd1000000007);

  typedef struct packed {
    val_t scale;
    val_t offset;
  } tag_t;

endpackage

// ===== sv/rau_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rau_affine.sv =====
// Five-stage pipelined unit: y = (a * b + c) mod PRIME, with Barrett reduction.
// Depends on rau_pkg.
module rau_affine #(
  parameter int TAG_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rau_pkg::val_t     in_a,
  input  rau_pkg::val_t     in_b,
  input  rau_pkg::val_t     in_c,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output rau_pkg::val_t     out_y,
  output logic [TAG_W-1:0]  out_tag,
  output logic              busy
);
  import rau_pkg::*;

  localparam int NSTG = 5;
  localparam logic [31:0] P32   = 32'(PRIME);
  localparam logic [31:0] TWO_P = 32'(PRIME) * 32'd2;

  logic [NSTG-1:0]  vld_r;
  logic [TAG_W-1:0] tag_r [NSTG];
  logic [59:0]      prod_r;
  val_t             c1_r;
  logic [59:0]      x_r;
  logic [61:0]      t_r;
  logic [31:0]      xlo3_r;
  logic [31:0]      xlo4_r;
  logic [31:0]      qp_r;
  val_t             y_r;
  logic [31:0]      rem_nxt;
  val_t             y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // remainder after the quotient estimate is below three times the prime
  always_comb begin
    rem_nxt = xlo4_r - qp_r;
    if (rem_nxt >= TWO_P) begin
      y_nxt = 30'(rem_nxt - TWO_P);
    end else if (rem_nxt >= P32) begin
      y_nxt = 30'(rem_nxt - P32);
    end else begin
      y_nxt = 30'(rem_nxt);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 60'(in_a) * 60'(in_b);
    c1_r   <= in_c;
    x_r    <= prod_r + 60'(c1_r);
    t_r    <= 62'(x_r[59:29]) * 62'(BARRETT_M);
    xlo3_r <= x_r[31:0];
    qp_r   <= 32'(t_r[61:31]) * P32;
    xlo4_r <= xlo3_r;
    y_r    <= y_nxt;
    tag_r[0] <= in_tag;
    for (int i = 1; i < NSTG; i++) begin
      tag_r[i] <= tag_r[i-1];
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_y     = y_r;
  assign out_tag   = tag_r[NSTG-1];
  assign busy      = |vld_r;

endmodule

// ===== sv/range_affine_update_point_query.sv =====
// Top level of the range affine update block: sequencer, element RAM, tag RAM
// and two modular affine pipelines. Depends on rau_pkg, rau_ram, rau_affine.
//
// Keeps residues modulo 1000000007 at indices 1..length, split into blocks of
// BLOCK_SIZE with a lazy scale/offset tag per block held in a tag RAM. After
// reset a clearing pass writes every tag (one block a cycle) before the first
// word is taken. One word is worked on at a time, set by the five-stage modular
// pipeline and the one read port of each RAM: a query reads one element and the
// tag of its block, a load rewrites the block that holds its index, and a range
// add or multiply rewrites its end blocks and then updates the tag of each
// wholly covered block. A finished query result waits in the output register
// while the next word is taken.
module range_affine_update_point_query #(
  parameter int MAX_ENTRIES = 1024,
  parameter int BLOCK_SIZE  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rau_pkg::kind_t       in_kind,
  input  rau_pkg::idx_t        in_first_index,
  input  rau_pkg::idx_t        in_last_index,
  input  rau_pkg::val_t        in_operand_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rau_pkg::val_t        out_element_value,
  input  logic                 cfg_wr_en,
  input  rau_pkg::idx_t        cfg_wr_data
);
  import rau_pkg::*;

  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NB   = (MAX_ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BW   = (NB > 1) ? $clog2(NB) : 1;
  localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int LW   = XW + 1;
  localparam int DS   = XW + 8;
  localparam int DM_W = DS + 1;
  localparam logic [DM_W-1:0] DIV_M =
    DM_W'(((64'd1 << DS) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DEC   = 4'd2;
  localparam logic [3:0] ST_BLK   = 4'd3;
  localparam logic [3:0] ST_PLAN  = 4'd4;
  localparam logic [3:0] ST_TRD   = 4'd5;
  localparam logic [3:0] ST_TCMP  = 4'd6;
  localparam logic [3:0] ST_TWT   = 4'd7;
  localparam logic [3:0] ST_ESTR  = 4'd8;
  localparam logic [3:0] ST_EDRN  = 4'd9;
  localparam logic [3:0] ST_MID   = 4'd10;
  localparam logic [3:0] ST_MDRN  = 4'd11;
  localparam logic [3:0] ST_QRD   = 4'd12;
  localparam logic [3:0] ST_QIS   = 4'd13;
  localparam logic [3:0] ST_QWT   = 4'd14;

  // block of a zero-based address, by reciprocal multiplication (exact here)
  function automatic logic [BW-1:0] blk_of(input logic [XW-1:0] a);
    logic [XW+DM_W-1:0] p;
    p = (XW+DM_W)'(a) * (XW+DM_W)'(DIV_M);
    return BW'(p >> DS);
  endfunction

  function automatic logic [XW-1:0] blk_start(input logic [BW-1:0] b);
    return XW'(XW'(b) * XW'(BLOCK_SIZE));
  endfunction

  function automatic logic [XW-1:0] blk_end(input logic [BW-1:0] b);
    logic [XW:0] e;
    e = (XW+1)'(blk_start(b)) + (XW+1)'(BLOCK_SIZE - 1);
    if (e > (XW+1)'(MAX_ENTRIES - 1)) begin
      e = (XW+1)'(MAX_ENTRIES - 1);
    end
    return XW'(e);
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  kind_t         kind_r, kind_nxt;
  idx_t          first_r, first_nxt;
  idx_t          last_r, last_nxt;
  val_t          d_r, d_nxt;
  val_t          coef_a_r, coef_a_nxt;
  val_t          coef_b_r, coef_b_nxt;
  logic [XW-1:0] lo_a_r, lo_a_nxt;
  logic [XW-1:0] hi_a_r, hi_a_nxt;
  logic          empty_r, empty_nxt;
  logic [BW-1:0] bl_r, bl_nxt;
  logic [BW-1:0] br_r, br_nxt;
  logic [BW-1:0] cur_blk_r, cur_blk_nxt;
  logic [XW-1:0] ra_r, ra_nxt;
  logic [XW-1:0] rb_r, rb_nxt;
  logic          part_r, part_nxt;
  logic [XW-1:0] addr_r, addr_nxt;
  logic [XW-1:0] end_r, end_nxt;
  val_t          s_r, s_nxt;
  val_t          o_r, o_nxt;
  val_t          s2_r, s2_nxt;
  val_t          o2_r, o2_nxt;
  logic [BW-1:0] mid_r, mid_nxt;
  logic          erd_v_r, erd_v_nxt;
  logic [XW-1:0] erd_a_r, erd_a_nxt;
  logic          trd_v_r, trd_v_nxt;
  logic [BW-1:0] trd_a_r, trd_a_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  val_t          out_value_r, out_value_nxt;

  logic          elem_we;
  logic [AW-1:0] elem_waddr, elem_raddr;
  val_t          elem_wdata, elem_rdata;
  logic          tag_we;
  logic [BW-1:0] tag_waddr, tag_raddr;
  tag_t          tag_wdata, tag_rdata;

  logic          lane_v;
  val_t          l0_a, l0_b, l0_c, l1_a, l1_b, l1_c;
  logic [XW-1:0] lane_tag;
  logic          l0_out_v, l0_busy;
  val_t          l0_y, l1_y;
  logic [XW-1:0] l0_tag;

  rau_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  rau_ram #(.WIDTH($bits(tag_t)), .DEPTH(NB)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  rau_affine #(.TAG_W(XW)) u_lane0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_v),
    .in_a      (l0_a),
    .in_b      (l0_b),
    .in_c      (l0_c),
    .in_tag    (lane_tag),
    .out_valid (l0_out_v),
    .out_y     (l0_y),
    .out_tag   (l0_tag),
    .busy      (l0_busy)
  );

  rau_affine #(.TAG_W(XW)) u_lane1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_v),
    .in_a      (l1_a),
    .in_b      (l1_b),
    .in_c      (l1_c),
    .in_tag    (lane_tag),
    .out_valid (),
    .out_y     (l1_y),
    .out_tag   (),
    .busy      ()
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_element_value = out_value_r;

  always_comb begin
    logic [LW-1:0] fi;
    logic [LW-1:0] la;
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
    logic          hit;
    logic          in_rng;

    state_nxt     = state_r;
    len_nxt       = len_r;
    kind_nxt      = kind_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    coef_a_nxt    = coef_a_r;
    coef_b_nxt    = coef_b_r;
    lo_a_nxt      = lo_a_r;
    hi_a_nxt      = hi_a_r;
    empty_nxt     = empty_r;
    bl_nxt        = bl_r;
    br_nxt        = br_r;
    cur_blk_nxt   = cur_blk_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    part_nxt      = part_r;
    addr_nxt      = addr_r;
    end_nxt       = end_r;
    s_nxt         = s_r;
    o_nxt         = o_r;
    s2_nxt        = s2_r;
    o2_nxt        = o2_r;
    mid_nxt       = mid_r;
    erd_v_nxt     = 1'b0;
    erd_a_nxt     = erd_a_r;
    trd_v_nxt     = 1'b0;
    trd_a_nxt     = trd_a_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    elem_we    = 1'b0;
    elem_waddr = l0_tag[AW-1:0];
    elem_wdata = l0_y;
    elem_raddr = addr_r[AW-1:0];
    tag_we     = 1'b0;
    tag_waddr  = BW'(l0_tag);
    tag_wdata  = '{scale: l0_y, offset: l1_y};
    tag_raddr  = cur_blk_r;

    lane_v   = 1'b0;
    l0_a     = coef_a_r;
    l0_b     = tag_rdata.scale;
    l0_c     = '0;
    l1_a     = coef_a_r;
    l1_b     = tag_rdata.offset;
    l1_c     = coef_b_r;
    lane_tag = erd_a_r;

    fi     = LW'(first_r);
    la     = LW'(last_r);
    lo     = fi;
    hi     = fi;
    hit    = (fi != '0) && (fi <= len_r);
    in_rng = (erd_a_r >= ra_r) && (erd_a_r <= rb_r);

    if (cfg_wr_en) begin
      len_nxt = (LW'(cfg_wr_data) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(cfg_wr_data);
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // feed the pipelines: tag compose, query, element stream or tag stream
    if (state_r == ST_TCMP) begin
      lane_v = 1'b1;
    end else if (state_r == ST_QIS) begin
      lane_v = 1'b1;
      l0_a   = tag_rdata.scale;
      l0_b   = elem_rdata;
      l0_c   = tag_rdata.offset;
    end else if (erd_v_r) begin
      lane_v = 1'b1;
      l0_a   = in_rng ? s2_r : s_r;
      l0_b   = elem_rdata;
      l0_c   = in_rng ? o2_r : o_r;
    end else if (trd_v_r) begin
      lane_v   = 1'b1;
      lane_tag = XW'(trd_a_r);
    end

    // write back pipeline results
    if (l0_out_v && (state_r == ST_ESTR || state_r == ST_EDRN)) begin
      elem_we = 1'b1;
    end
    if (l0_out_v && (state_r == ST_MID || state_r == ST_MDRN)) begin
      tag_we = 1'b1;
    end

    case (state_r)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_r;
        tag_wdata = '{scale: VAL_ONE, offset: '0};
        clr_nxt   = clr_r + BW'(1);
        if (clr_r == BW'(NB - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          first_nxt = in_first_index;
          last_nxt  = in_last_index;
          d_nxt     = (in_operand_value >= PRIME) ? in_operand_value - PRIME : in_operand_value;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (kind_r == KIND_LOAD || kind_r == KIND_QUERY) begin
          empty_nxt = !hit;
        end else begin
          lo        = (fi == '0) ? LW'(1) : fi;
          hi        = (la > len_r) ? len_r : la;
          empty_nxt = (lo > hi);
        end
        lo_a_nxt = XW'(lo - LW'(1));
        hi_a_nxt = XW'(hi - LW'(1));
        case (kind_r)
          KIND_LOAD: begin
            coef_a_nxt = '0;
            coef_b_nxt = d_r;
          end
          KIND_ADD: begin
            coef_a_nxt = VAL_ONE;
            coef_b_nxt = d_r;
          end
          default: begin
            coef_a_nxt = d_r;
            coef_b_nxt = '0;
          end
        endcase
        state_nxt = ST_BLK;
      end
      ST_BLK: begin
        bl_nxt = blk_of(lo_a_r);
        br_nxt = blk_of(hi_a_r);
        if (kind_r == KIND_QUERY) begin
          state_nxt = ST_QRD;
        end else if (empty_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cur_blk_nxt = bl_r;
        ra_nxt      = lo_a_r;
        rb_nxt      = (bl_r == br_r) ? hi_a_r : blk_end(bl_r);
        part_nxt    = 1'b0;
        state_nxt   = ST_TRD;
      end
      ST_TRD: begin
        state_nxt = ST_TCMP;
      end
      ST_TCMP: begin
        // take the old tags, start the composed tags, reset the block tags
        s_nxt     = tag_rdata.scale;
        o_nxt     = tag_rdata.offset;
        tag_we    = 1'b1;
        tag_waddr = cur_blk_r;
        tag_wdata = '{scale: VAL_ONE, offset: '0};
        addr_nxt  = blk_start(cur_blk_r);
        end_nxt   = blk_end(cur_blk_r);
        state_nxt = ST_TWT;
      end
      ST_TWT: begin
        if (l0_out_v) begin
          s2_nxt    = l0_y;
          o2_nxt    = l1_y;
          state_nxt = ST_ESTR;
        end
      end
      ST_ESTR: begin
        erd_v_nxt = 1'b1;
        erd_a_nxt = addr_r;
        addr_nxt  = addr_r + XW'(1);
        if (addr_r == end_r) begin
          state_nxt = ST_EDRN;
        end
      end
      ST_EDRN: begin
        if (!erd_v_r && !l0_busy) begin
          if (!part_r && (bl_r != br_r)) begin
            part_nxt    = 1'b1;
            cur_blk_nxt = br_r;
            ra_nxt      = blk_start(br_r);
            rb_nxt      = hi_a_r;
            state_nxt   = ST_TRD;
          end else if ((bl_r != br_r) && (BW'(br_r - bl_r) > BW'(1))) begin
            mid_nxt   = bl_r + BW'(1);
            state_nxt = ST_MID;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MID: begin
        tag_raddr = mid_r;
        trd_v_nxt = 1'b1;
        trd_a_nxt = mid_r;
        mid_nxt   = mid_r + BW'(1);
        if (mid_r == br_r - BW'(1)) begin
          state_nxt = ST_MDRN;
        end
      end
      ST_MDRN: begin
        if (!trd_v_r && !l0_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        // hold until the result register is free
        if (!out_valid_r) begin
          if (empty_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            state_nxt     = ST_IDLE;
          end else begin
            tag_raddr  = bl_r;
            elem_raddr = lo_a_r[AW-1:0];
            state_nxt  = ST_QIS;
          end
        end
      end
      ST_QIS: begin
        state_nxt = ST_QWT;
      end
      ST_QWT: begin
        if (l0_out_v) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = l0_y;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      len_r       <= LW'(MAX_ENTRIES);
      out_valid_r <= 1'b0;
      erd_v_r     <= 1'b0;
      trd_v_r     <= 1'b0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      erd_v_r     <= erd_v_nxt;
      trd_v_r     <= trd_v_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    d_r         <= d_nxt;
    coef_a_r    <= coef_a_nxt;
    coef_b_r    <= coef_b_nxt;
    lo_a_r      <= lo_a_nxt;
    hi_a_r      <= hi_a_nxt;
    empty_r     <= empty_nxt;
    bl_r        <= bl_nxt;
    br_r        <= br_nxt;
    cur_blk_r   <= cur_blk_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    part_r      <= part_nxt;
    addr_r      <= addr_nxt;
    end_r       <= end_nxt;
    s_r         <= s_nxt;
    o_r         <= o_nxt;
    s2_r        <= s2_nxt;
    o2_r        <= o2_nxt;
    mid_r       <= mid_nxt;
    erd_a_r     <= erd_a_nxt;
    trd_a_r     <= trd_a_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

// ===== sv/rau_checker.sv =====
// Port-level checker for the range affine update block, bound to the top level.
// Depends on rau_pkg and range_affine_update_point_query_macros.svh.
`include "range_affine_update_point_query_macros.svh"

module rau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rau_pkg::val_t out_element_value
);

  // a stalled result word must hold
  `RAU_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_element_value), "result word dropped or changed while stalled")

  // tag clearing pass runs right after reset, so no word is taken then
  `RAU_ASSERT_SAME(a_reset_busy, clk, !rst_n, $past(!rst_n), !in_ready, "word taken during tag clearing")

  // one word at a time: busy in the cycle after a word is taken
  `RAU_ASSERT_NEXT(a_accept_busy, clk, !rst_n, in_valid && in_ready, !in_ready, "second word taken before the first finished")

endmodule

bind range_affine_update_point_query rau_checker u_rau_checker (.*);
